// ----- rtl/core/lpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_pkg: shared definitions for the literal parser and ALU
// Character codes, argument kinds, status codes, the command and status
// groups between controller and datapath, and the hex digit decode.
// ----------------------------------------------------------------------------
package lpa_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 16;
   localparam int RESULT_WIDTH        = 16;

   localparam logic [1:0] KIND_FIRST  = 2'd0;
   localparam logic [1:0] KIND_OPER   = 2'd1;
   localparam logic [1:0] KIND_SECOND = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DIVZERO = 2'd1;
   localparam logic [1:0] STATUS_BADOP   = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_PIPE  = 8'h7C;
   localparam logic [7:0] CH_CARET = 8'h5E;

   localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd10;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_step;
      logic load_imm;
      logic load_div;
   } lpa_cmd_type;

   typedef struct packed {
      logic final_nul;
      logic div_needed;
   } lpa_stat_type;

   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c inside {[CH_0:CH_9]}) begin
         d = c - CH_0;
      end else if (c inside {[CH_UA:CH_UF]}) begin
         d = c - CH_UA + HEX_ALPHA_OFFSET;
      end else if (c inside {[CH_LA:CH_LF]}) begin
         d = c - CH_LA + HEX_ALPHA_OFFSET;
      end
      return d[3:0];
   endfunction

endpackage

// ----- rtl/core/literal_parse_and_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_parse_and_alu: streaming literal parser and 16-bit calculator
// Parses two literal operands and an operator from NUL-ended arguments and
// returns the result and a status on the NUL of the second operand.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_kind[1:0], req_ch[7:0]
//   rsp      out        rsp_valid/rsp_stall  rsp_result[15:0], rsp_status[1:0]
//
// One character transfer per cycle, but every character stalls during a
// division and a closing NUL stalls while an earlier result is still held.
// A divide with a non-zero divisor runs the restoring divider one quotient
// bit per cycle. All other results appear in the cycle after the closing NUL.
// Synchronous reset clears the parser and operator.
// ----------------------------------------------------------------------------
module literal_parse_and_alu import lpa_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              req_ch,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [RESULT_WIDTH-1:0] rsp_result,
   output logic [1:0]              rsp_status
);

   lpa_cmd_type  cmd;
   lpa_stat_type stat;

   lpa_ctrl #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpa_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_kind),
      .req_ch     (req_ch),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_result (rsp_result),
      .rsp_status (rsp_status)
   );

endmodule

// ----- rtl/core/lpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_ctrl: handshake and division sequencer
// Accepts characters, issues parse and response commands, steps the divider
// one quotient bit per cycle and owns the response valid flag.
// ----------------------------------------------------------------------------
module lpa_ctrl import lpa_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  lpa_stat_type stat,
   output lpa_cmd_type  cmd
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   typedef enum logic {ST_IDLE, ST_DIV} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_take;
   logic             cnt_done;

   assign rsp_take  = rsp_valid_ff & ~rsp_stall;
   assign cnt_done  = (cnt_ff == CNT_W'(VALUE_WIDTH));
   assign req_stall = (state_ff != ST_IDLE) | (stat.final_nul & rsp_valid_ff & rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.accept   = req_valid & ~req_stall;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && stat.final_nul) begin
               if (stat.div_needed) begin
                  cmd.div_start = 1'b1;
                  cnt_in        = '0;
                  state_in      = ST_DIV;
               end else begin
                  cmd.load_imm = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (!cnt_done) begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
            end else if (!rsp_valid_ff || rsp_take) begin
               cmd.load_div = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.load_imm || cmd.load_div) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_imm || cmd.load_div) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response loaded over a pending transfer");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == ST_DIV && cnt_ff == '0))
      else $error("division did not start cleanly");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(VALUE_WIDTH))
      else $error("division counter out of range");

   a_div_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_div |=> rsp_valid_ff)
      else $error("division result not presented");
`endif

endmodule

// ----- rtl/core/lpa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_datapath: literal parser, operator latch, ALU and divider
// Parses decimal, hex and binary literals, latches the operator, forms
// combinational ALU results and runs a restoring divider one bit per step.
// ----------------------------------------------------------------------------
module lpa_datapath import lpa_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              req_ch,
   input  lpa_cmd_type             cmd,
   output lpa_stat_type            stat,
   output logic [RESULT_WIDTH-1:0] rsp_result,
   output logic [1:0]              rsp_status
);

   localparam int W     = VALUE_WIDTH;
   localparam int LOW_W = (VALUE_WIDTH < RESULT_WIDTH) ? VALUE_WIDTH : RESULT_WIDTH;

   typedef enum logic [1:0] {RADIX_DEC, RADIX_HEX, RADIX_BIN} radix_type;

   logic [W-1:0] first_ff, first_in;
   logic [W-1:0] acc_ff, acc_in;
   radix_type    radix_ff, radix_in;
   logic [1:0]   pos_ff, pos_in;
   logic         fzero_ff, fzero_in;
   logic [7:0]   op_ff, op_in;
   logic         seen_ff, seen_in;

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] dvs_ff, dvs_in;

   logic [RESULT_WIDTH-1:0] result_ff, result_in;
   logic [1:0]              status_ff, status_in;

   logic [W-1:0]     step_val;
   logic [3:0]       dec_digit;
   logic [W:0]       trial;
   logic [LOW_W-1:0] prod;
   logic [W-1:0]     alu_val;
   logic [1:0]       alu_status;
   logic             is_operand;

   assign is_operand      = (req_kind == KIND_FIRST) || (req_kind == KIND_SECOND);
   assign stat.final_nul  = (req_kind == KIND_SECOND) && (req_ch == CH_NUL);
   assign stat.div_needed = (op_ff == CH_SLASH) && (acc_ff != '0);

   assign dec_digit = 4'(req_ch - CH_0);

   always_comb begin
      case (radix_ff)
         RADIX_HEX: step_val = {acc_ff[W-5:0], hex_digit(req_ch)};
         RADIX_BIN: step_val = {acc_ff[W-2:0], (req_ch == CH_1)};
         RADIX_DEC: begin
            if (req_ch inside {[CH_0:CH_9]}) begin
               step_val = (acc_ff << 3) + (acc_ff << 1) + W'(dec_digit);
            end else begin
               step_val = acc_ff;
            end
         end
         default: step_val = acc_ff;
      endcase
   end

   assign prod = first_ff[LOW_W-1:0] * acc_ff[LOW_W-1:0];

   always_comb begin
      alu_status = STATUS_OK;
      case (op_ff)
         CH_PLUS:  alu_val = first_ff + acc_ff;
         CH_MINUS: alu_val = first_ff - acc_ff;
         CH_STAR:  alu_val = W'(prod);
         CH_AMP:   alu_val = first_ff & acc_ff;
         CH_PIPE:  alu_val = first_ff | acc_ff;
         CH_CARET: alu_val = first_ff ^ acc_ff;
         CH_SLASH: begin
            alu_val    = '0;
            alu_status = STATUS_DIVZERO;
         end
         default: begin
            alu_val    = '0;
            alu_status = STATUS_BADOP;
         end
      endcase
   end

   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};

   always_comb begin
      first_in  = first_ff;
      acc_in    = acc_ff;
      radix_in  = radix_ff;
      pos_in    = pos_ff;
      fzero_in  = fzero_ff;
      op_in     = op_ff;
      seen_in   = seen_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      result_in = result_ff;
      status_in = status_ff;

      if (cmd.accept) begin
         if (req_kind == KIND_OPER) begin
            if (req_ch == CH_NUL) begin
               if (!seen_ff) begin
                  op_in = CH_NUL;
               end
               seen_in = 1'b0;
            end else if (!seen_ff) begin
               op_in   = req_ch;
               seen_in = 1'b1;
            end
         end else if (is_operand && req_ch != CH_NUL) begin
            case (pos_ff)
               2'd0: begin
                  fzero_in = (req_ch == CH_0);
                  acc_in   = step_val;
                  pos_in   = 2'd1;
               end
               2'd1: begin
                  if (fzero_ff && (req_ch == CH_LX || req_ch == CH_UX)) begin
                     radix_in = RADIX_HEX;
                     acc_in   = '0;
                  end else if (fzero_ff && (req_ch == CH_LB || req_ch == CH_UB)) begin
                     radix_in = RADIX_BIN;
                     acc_in   = '0;
                  end else begin
                     acc_in = step_val;
                  end
                  pos_in = 2'd2;
               end
               default: begin
                  acc_in = step_val;
               end
            endcase
         end else if (is_operand) begin
            if (req_kind == KIND_FIRST) begin
               first_in = acc_ff;
            end else begin
               seen_in = 1'b0;
            end
            acc_in   = '0;
            radix_in = RADIX_DEC;
            pos_in   = 2'd0;
            fzero_in = 1'b0;
         end
      end

      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = first_ff;
         dvs_in = acc_ff;
      end else if (cmd.div_step) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end

      if (cmd.load_imm) begin
         result_in = RESULT_WIDTH'(alu_val[LOW_W-1:0]);
         status_in = alu_status;
      end else if (cmd.load_div) begin
         result_in = RESULT_WIDTH'(quo_ff[LOW_W-1:0]);
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         acc_ff   <= '0;
         radix_ff <= RADIX_DEC;
         pos_ff   <= 2'd0;
         fzero_ff <= 1'b0;
         op_ff    <= CH_NUL;
         seen_ff  <= 1'b0;
      end else begin
         first_ff <= first_in;
         acc_ff   <= acc_in;
         radix_ff <= radix_in;
         pos_ff   <= pos_in;
         fzero_ff <= fzero_in;
         op_ff    <= op_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      result_ff <= result_in;
      status_ff <= status_in;
   end

   assign rsp_result = result_ff;
   assign rsp_status = status_ff;

endmodule

// ----- test/literal_parse_and_alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_parse_and_alu_checker: scoreboard for the literal parser and ALU
// Follows every character transfer with its own model of the operand parser,
// the operator latch and the held first operand. Queues the answer that each
// closing NUL of the second operand should give, and compares every result
// transfer field by field against the oldest queued answer.
// ----------------------------------------------------------------------------
module literal_parse_and_alu_checker import lpa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              req_ch,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [RESULT_WIDTH-1:0] rsp_result,
   input  logic [1:0]              rsp_status,
   output int                      outstanding,
   output int                      errors
);

   typedef enum logic [1:0] {RADIX_DEC, RADIX_HEX, RADIX_BIN} radix_type;

   typedef struct packed {
      logic [15:0] result;
      logic [1:0]  status;
   } answer_type;

   logic [15:0] held_lhs;
   logic [15:0] acc;
   radix_type   radix;
   logic [1:0]  char_count;
   logic        lead_zero;
   logic [7:0]  op_char;
   logic        op_latched;
   answer_type  answers[$];

   initial begin
      errors = 0;
      outstanding = 0;
   end

   task automatic clear_operand();
      acc = '0;
      radix = RADIX_DEC;
      char_count = '0;
      lead_zero = 1'b0;
   endtask

   task automatic shift_digit(input logic [7:0] c);
      logic [3:0] nib;
      nib = '0;
      if (c >= CH_0 && c <= CH_9) nib = 4'(c - CH_0);
      else if (c >= CH_UA && c <= CH_UF) nib = 4'(c - CH_UA + 8'd10);
      else if (c >= CH_LA && c <= CH_LF) nib = 4'(c - CH_LA + 8'd10);
      case (radix)
         RADIX_HEX: acc = {acc[11:0], nib};
         RADIX_BIN: acc = {acc[14:0], c == CH_1};
         default: begin
            if (c >= CH_0 && c <= CH_9) acc = acc * 16'd10 + 16'(nib);
         end
      endcase
   endtask

   task automatic take_operand_char(input logic [7:0] c);
      if (char_count == 2'd0) begin
         lead_zero = (c == CH_0);
         shift_digit(c);
         char_count = 2'd1;
      end else if (char_count == 2'd1) begin
         if (lead_zero && (c == CH_LX || c == CH_UX)) begin
            radix = RADIX_HEX;
            acc = '0;
         end else if (lead_zero && (c == CH_LB || c == CH_UB)) begin
            radix = RADIX_BIN;
            acc = '0;
         end else begin
            shift_digit(c);
         end
         char_count = 2'd2;
      end else begin
         shift_digit(c);
      end
   endtask

   task automatic take_char(input logic [1:0] kind, input logic [7:0] c);
      answer_type ans;
      ans.result = '0;
      ans.status = STATUS_OK;
      case (kind)
         KIND_OPER: begin
            if (c == CH_NUL) begin
               if (!op_latched) op_char = CH_NUL;
               op_latched = 1'b0;
            end else if (!op_latched) begin
               op_char = c;
               op_latched = 1'b1;
            end
         end
         KIND_FIRST, KIND_SECOND: begin
            if (c != CH_NUL) begin
               take_operand_char(c);
            end else if (kind == KIND_FIRST) begin
               held_lhs = acc;
               clear_operand();
            end else begin
               case (op_char)
                  CH_PLUS:  ans.result = held_lhs + acc;
                  CH_MINUS: ans.result = held_lhs - acc;
                  CH_STAR:  ans.result = held_lhs * acc;
                  CH_SLASH: begin
                     if (acc == '0) ans.status = STATUS_DIVZERO;
                     else ans.result = held_lhs / acc;
                  end
                  CH_AMP:   ans.result = held_lhs & acc;
                  CH_PIPE:  ans.result = held_lhs | acc;
                  CH_CARET: ans.result = held_lhs ^ acc;
                  default:  ans.status = STATUS_BADOP;
               endcase
               if (ans.status != STATUS_OK) ans.result = '0;
               answers.push_back(ans);
               clear_operand();
               op_latched = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         held_lhs = '0;
         clear_operand();
         op_char = CH_NUL;
         op_latched = 1'b0;
         answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               $display("%0t: result %h status %0d with no answer pending",
                        $time, rsp_result, rsp_status);
               errors++;
            end else begin
               want = answers.pop_front();
               if (rsp_result != want.result) begin
                  $display("%0t: result expected %h actual %h",
                           $time, want.result, rsp_result);
                  errors++;
               end
               if (rsp_status != want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) take_char(req_kind, req_ch);
      end
      outstanding = answers.size();
   end

endmodule

// ----- test/literal_parse_and_alu_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_parse_and_alu_test: top of the literal parser and ALU testbench
// Drives directed commands covering all operators but &, every radix prefix and
// malformed argument, then random well-formed commands mixed with noise,
// interleaved operands and re-latched operators, with random idling on both
// channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module literal_parse_and_alu_test import lpa_pkg::*;;

   localparam logic [1:0] KIND_SPARE  = 2'd3;
   localparam int         ITEM_TARGET = 1150;
   localparam int         QUIET_FROM  = 950;
   localparam int         CYCLE_LIMIT = 400000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_kind;
   logic [7:0]              req_ch;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [RESULT_WIDTH-1:0] rsp_result;
   logic [1:0]              rsp_status;

   int outstanding;
   int errors;
   int cycles = 0;
   int stall_left = 0;
   int sent = 0;
   bit idle_on = 1'b1;

   logic [7:0] op_codes [7] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_AMP, CH_PIPE,
                                CH_CARET};
   string hex_set = "0123456789abcdefABCDEF";
   string plain_operands [4] = '{"", "0", "1", "65535"};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   literal_parse_and_alu i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_ch     (req_ch),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .rsp_status (rsp_status)
   );

   literal_parse_and_alu_checker i_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_ch      (req_ch),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result),
      .rsp_status  (rsp_status),
      .outstanding (outstanding),
      .errors      (errors)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("literal_parse_and_alu: mismatch");
         $finish;
      end
   end

   // hold off results in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic string add_char(input string s, input logic [7:0] c);
      string t;
      t = {s, " "};
      t.putc(t.len() - 1, c);
      return t;
   endfunction

   function automatic logic [7:0] any_char();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic string make_operand();
      string s;
      s = "";
      case ($urandom_range(0, 5))
         0, 1: begin
            repeat ($urandom_range(0, 6))
               s = add_char(s, $urandom_range(0, 7) == 0 ? any_char()
                                                         : 8'(CH_0 + $urandom_range(0, 9)));
         end
         2: begin
            s = $urandom_range(0, 1) ? "0x" : "0X";
            repeat ($urandom_range(0, 5))
               s = add_char(s, $urandom_range(0, 7) == 0 ? any_char()
                                                         : hex_set[$urandom_range(0, 21)]);
         end
         3: begin
            s = $urandom_range(0, 1) ? "0b" : "0B";
            repeat ($urandom_range(0, 20))
               s = add_char(s, $urandom_range(0, 9) == 0 ? any_char()
                                                         : ($urandom_range(0, 1) ? CH_1 : CH_0));
         end
         4: begin
            repeat ($urandom_range(1, 6)) s = add_char(s, any_char());
         end
         default: s = plain_operands[$urandom_range(0, 3)];
      endcase
      return s;
   endfunction

   function automatic string make_operator();
      string s;
      int pick;
      s = "";
      pick = $urandom_range(0, 11);
      if (pick <= 8 || pick == 11) s = add_char(s, op_codes[$urandom_range(0, 6)]);
      else if (pick == 9) s = add_char(s, any_char());
      if (pick == 8) repeat ($urandom_range(1, 3)) s = add_char(s, any_char());
      return s;
   endfunction

   // entered and left at a falling edge
   task automatic send_char(input logic [1:0] kind, input logic [7:0] ch);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_ch <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (kind != KIND_SPARE) sent++;
   endtask

   task automatic send_arg(input logic [1:0] kind, input string s);
      for (int i = 0; i < s.len(); i++) send_char(kind, s[i]);
      send_char(kind, CH_NUL);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   initial begin
      string s;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_FIRST;
      req_ch = CH_NUL;
      rsp_stall = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wrap on add, then reuse the held first operand
      send_arg(KIND_FIRST, "0xFfFf");
      send_arg(KIND_OPER, "+");
      send_arg(KIND_SECOND, "1");
      send_arg(KIND_OPER, "^");
      send_arg(KIND_SECOND, "0b");
      send_arg(KIND_OPER, "|&");
      send_arg(KIND_SECOND, "99999");
      send_arg(KIND_OPER, "*");
      send_arg(KIND_SECOND, "0B1z1");
      send_arg(KIND_FIRST, "9a9");
      send_arg(KIND_OPER, "/");
      send_arg(KIND_SECOND, "");
      send_arg(KIND_OPER, "/");
      send_arg(KIND_SECOND, "0X1g");
      send_arg(KIND_OPER, "-");
      send_arg(KIND_SECOND, "0x");
      send_char(KIND_SPARE, 8'hFF);
      send_arg(KIND_OPER, "");
      send_arg(KIND_SECOND, "7");
      send_arg(KIND_SECOND, "3");
      drain();

      while (sent < ITEM_TARGET) begin
         if (sent >= QUIET_FROM) idle_on = 1'b0;
         else if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
         if ($urandom_range(0, 29) == 0) drain();
         case ($urandom_range(0, 11))
            0: begin
               repeat ($urandom_range(1, 8))
                  send_char(2'($urandom_range(0, 3)),
                            $urandom_range(0, 3) == 0 ? CH_NUL : 8'($urandom_range(0, 255)));
            end
            1: begin
               // spread one operand over both operand kinds
               s = make_operand();
               for (int i = 0; i < s.len(); i++)
                  send_char($urandom_range(0, 1) ? KIND_SECOND : KIND_FIRST, s[i]);
               send_char($urandom_range(0, 1) ? KIND_SECOND : KIND_FIRST, CH_NUL);
            end
            2: begin
               // latch a fresh operator after the argument has closed
               send_arg(KIND_OPER, make_operator());
               send_char(KIND_OPER, op_codes[$urandom_range(0, 6)]);
               send_arg(KIND_SECOND, make_operand());
            end
            default: begin
               if ($urandom_range(0, 15) != 0) send_arg(KIND_FIRST, make_operand());
               if ($urandom_range(0, 15) != 0) send_arg(KIND_OPER, make_operator());
               send_arg(KIND_SECOND, make_operand());
            end
         endcase
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("literal_parse_and_alu: match");
      end else begin
         $display("literal_parse_and_alu: mismatch");
      end
      $finish;
   end

endmodule
